// File: hdl/ckey_pkg.sv
// ----------------------------------------------------------------------------
// ckey_pkg
// Shared types, key codes and constants of the calculator key engine.
// ----------------------------------------------------------------------------
package ckey_pkg;

  localparam int MAX_DIGITS = 13;
  localparam int VAL_W      = 45;   // signed display / register width
  localparam int MAG_W      = 44;   // magnitude width
  localparam int IDX_W      = 6;    // bit index into a magnitude

  function automatic logic [63:0] calc_limit(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) p = p * 64'd10;
    return p - 64'd1;
  endfunction

  localparam logic [63:0] LIM64 = calc_limit(MAX_DIGITS);
  localparam logic signed [VAL_W-1:0] LIM = LIM64[VAL_W-1:0];

  // key codes
  localparam logic [3:0] KEY_DIGIT = 4'd0;
  localparam logic [3:0] KEY_CLEAR = 4'd1;
  localparam logic [3:0] KEY_BKSP  = 4'd2;
  localparam logic [3:0] KEY_NEG   = 4'd3;
  localparam logic [3:0] KEY_EQ    = 4'd4;
  localparam logic [3:0] KEY_ADD   = 4'd5;
  localparam logic [3:0] KEY_SUB   = 4'd6;
  localparam logic [3:0] KEY_MUL   = 4'd7;
  localparam logic [3:0] KEY_DIV   = 4'd8;
  localparam logic [3:0] KEY_MOD   = 4'd9;
  localparam logic [3:0] KEY_POW   = 4'd10;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2,
    OP_DIV = 3'd3, OP_MOD = 3'd4, OP_POW = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    KIND_SIMPLE = 2'd0, KIND_MUL = 2'd1, KIND_DIV = 2'd2, KIND_POW = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_POW_INIT, CMD_MUL_INIT, CMD_MUL_STEP,
    CMD_DIV_INIT, CMD_DIV_STEP, CMD_POW_UPD, CMD_WRITE
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  pow_direct;
    logic  pow_more;
    logic  last_bit;
    logic  out_busy;
  } stat_t;

endpackage

// File: hdl/ckey_in_if.sv
// ----------------------------------------------------------------------------
// ckey_in_if
// Key channel: one key press per word.
// ----------------------------------------------------------------------------
interface ckey_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] func;
  logic [3:0] digit;
  modport source (output valid, func, digit, input ready);
  modport sink   (input valid, func, digit, output ready);
endinterface

// File: hdl/ckey_out_if.sv
// ----------------------------------------------------------------------------
// ckey_out_if
// Result channel: displayed entry value, one word per key.
// ----------------------------------------------------------------------------
interface ckey_out_if;
  logic               valid;
  logic               ready;
  logic signed [44:0] shown_value;
  modport source (output valid, shown_value, input ready);
  modport sink   (input valid, shown_value, output ready);
endinterface

// File: hdl/ckey_ctrl.sv
// ----------------------------------------------------------------------------
// ckey_ctrl
// Sequencer: dispatches a key to the shift-add multiplier, the restoring
// divider or the power loop, then writes back.
// ----------------------------------------------------------------------------
module ckey_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ckey_pkg::stat_t st,
  output ckey_pkg::cmd_t  cmd
);
  import ckey_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_DISP = 7'b0000010, S_MUL  = 7'b0000100,
    S_DIV  = 7'b0001000, S_PCHK = 7'b0010000, S_PUPD = 7'b0100000,
    S_WRITE = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (st.kind)
          KIND_MUL: begin
            cmd        = CMD_MUL_INIT;
            state_next = S_MUL;
          end
          KIND_DIV: begin
            cmd        = CMD_DIV_INIT;
            state_next = S_DIV;
          end
          KIND_POW: begin
            if (st.pow_direct) state_next = S_WRITE;
            else begin
              cmd        = CMD_POW_INIT;
              state_next = S_PCHK;
            end
          end
          default: state_next = S_WRITE;
        endcase
      end
      S_MUL: begin
        cmd = CMD_MUL_STEP;
        if (st.last_bit) state_next = (st.kind == KIND_POW) ? S_PUPD : S_WRITE;
      end
      S_DIV: begin
        cmd = CMD_DIV_STEP;
        if (st.last_bit) state_next = S_WRITE;
      end
      S_PUPD: begin
        cmd        = CMD_POW_UPD;
        state_next = S_PCHK;
      end
      S_PCHK: begin
        if (st.pow_more) begin
          cmd        = CMD_MUL_INIT;
          state_next = S_MUL;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        if (!st.out_busy) begin
          cmd        = CMD_WRITE;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

// File: hdl/ckey_dpath.sv
// ----------------------------------------------------------------------------
// ckey_dpath
// Entry, accumulator and pending operator, with a one-bit-a-cycle multiplier,
// a restoring divider, the power counter and the output register.
// ----------------------------------------------------------------------------
module ckey_dpath (
  input  logic                    clk,
  input  logic                    rst,
  input  ckey_pkg::cmd_t          cmd,
  output ckey_pkg::stat_t         st,
  input  logic [3:0]              in_func,
  input  logic [3:0]              in_digit,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [44:0]      out_value
);
  import ckey_pkg::*;

  logic signed [VAL_W-1:0] entry, acc;
  op_t                     pop;
  logic [3:0]              key_f, key_d;
  logic [MAG_W-1:0]        a_mag, b_mag, mx, my, dvd, q, m, cnt;
  logic                    a_neg, b_neg, ovf, psat;
  logic [MAG_W+1:0]        p;
  logic [MAG_W:0]          rem;
  logic [IDX_W-1:0]        idx;

  function automatic logic [MAG_W-1:0] mag(input logic signed [VAL_W-1:0] v);
    logic signed [VAL_W-1:0] t;
    t = v[VAL_W-1] ? -v : v;
    return t[MAG_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] sat(input logic neg);
    return neg ? -LIM : LIM;
  endfunction

  function automatic logic signed [VAL_W-1:0] smag(input logic neg,
                                                   input logic [MAG_W-1:0] v);
    logic signed [VAL_W-1:0] t;
    t = $signed({1'b0, v});
    return neg ? -t : t;
  endfunction

  // operator keys: add .. pow
  logic is_opkey;
  assign is_opkey = (key_f >= KEY_ADD) && (key_f <= KEY_POW);

  always_comb begin
    st.kind = KIND_SIMPLE;
    if (key_f == KEY_BKSP) st.kind = KIND_DIV;
    else if (key_f == KEY_EQ || is_opkey) begin
      case (pop)
        OP_MUL:         st.kind = KIND_MUL;
        OP_DIV, OP_MOD: st.kind = KIND_DIV;
        OP_POW:         st.kind = KIND_POW;
        default:        st.kind = KIND_SIMPLE;
      endcase
    end
  end

  assign st.pow_direct = b_neg || (b_mag == '0) || (a_mag <= MAG_W'(1));
  assign st.pow_more   = !psat && (cnt > MAG_W'(1));
  assign st.last_bit   = (idx == '0);
  assign st.out_busy   = out_valid && !out_ready;

  // ---- result of the pending operation ----
  logic signed [VAL_W:0]   wsum;
  logic signed [VAL_W-1:0] app_v, pow_v;
  logic                    pneg;

  assign pneg = a_neg && b_mag[0];

  always_comb begin
    if (b_neg)                 pow_v = '0;
    else if (b_mag == '0)      pow_v = VAL_W'(1);
    else if (a_mag == '0)      pow_v = '0;
    else if (a_mag == MAG_W'(1)) pow_v = smag(pneg, MAG_W'(1));
    else if (psat)             pow_v = sat(pneg);
    else                       pow_v = smag(pneg, m);
  end

  always_comb begin
    wsum = '0;
    case (pop)
      OP_SUB: wsum = $signed({acc[VAL_W-1], acc}) - $signed({entry[VAL_W-1], entry});
      default: wsum = $signed({acc[VAL_W-1], acc}) + $signed({entry[VAL_W-1], entry});
    endcase
    case (pop)
      OP_MUL: app_v = ovf ? sat(a_neg ^ b_neg) : smag(a_neg ^ b_neg, p[MAG_W-1:0]);
      OP_DIV: app_v = (b_mag == '0) ? sat(a_neg) : smag(a_neg ^ b_neg, q);
      OP_MOD: app_v = (b_mag == '0) ? sat(a_neg) : smag(a_neg, rem[MAG_W-1:0]);
      OP_POW: app_v = pow_v;
      default: begin
        if (wsum > $signed({LIM[VAL_W-1], LIM}))       app_v = LIM;
        else if (wsum < -$signed({LIM[VAL_W-1], LIM})) app_v = -LIM;
        else                                           app_v = wsum[VAL_W-1:0];
      end
    endcase
  end

  // ---- digit shift: |entry|*10 + d against the limit ----
  logic [3:0]              dd;
  logic [MAG_W+3:0]        em, t10;
  logic signed [VAL_W-1:0] dig_v;

  always_comb begin
    dd    = (key_d > 4'd9) ? 4'd9 : key_d;
    em    = {4'b0, mag(entry)};
    t10   = (em << 3) + (em << 1) + (MAG_W+4)'(dd);
    dig_v = (t10 > (MAG_W+4)'(LIM64)) ? sat(entry[VAL_W-1])
                                      : smag(entry[VAL_W-1], t10[MAG_W-1:0]);
  end

  // ---- next entry ----
  logic signed [VAL_W-1:0] entry_new;
  always_comb begin
    entry_new = entry;
    case (key_f)
      KEY_DIGIT: entry_new = dig_v;
      KEY_CLEAR: entry_new = '0;
      KEY_BKSP:  entry_new = smag(a_neg, q);
      KEY_NEG:   entry_new = -entry;
      KEY_EQ:    entry_new = app_v;
      default:   if (is_opkey) entry_new = '0;
    endcase
  end

  // ---- unit step logic ----
  logic [MAG_W+1:0] pn;
  logic [MAG_W:0]   rs;
  assign pn = {p[MAG_W:0], 1'b0} + (mx[idx] ? {2'b0, my} : '0);
  assign rs = {rem[MAG_W-1:0], dvd[idx]};

  always_ff @(posedge clk) begin
    if (rst) begin
      entry     <= '0;
      acc       <= '0;
      pop       <= OP_ADD;
      out_valid <= 1'b0;
    end else begin
      case (cmd)
        CMD_LOAD: begin
          key_f <= in_func;
          key_d <= in_digit;
          if (in_func == KEY_BKSP) begin
            a_mag <= mag(entry);
            a_neg <= entry[VAL_W-1];
            b_mag <= MAG_W'(10);
            b_neg <= 1'b0;
          end else begin
            a_mag <= mag(acc);
            a_neg <= acc[VAL_W-1];
            b_mag <= mag(entry);
            b_neg <= entry[VAL_W-1];
          end
        end
        CMD_POW_INIT: begin
          m    <= a_mag;
          cnt  <= b_mag;
          psat <= 1'b0;
        end
        CMD_MUL_INIT: begin
          mx  <= (st.kind == KIND_POW) ? a_mag : b_mag;
          my  <= (st.kind == KIND_POW) ? m : a_mag;
          p   <= '0;
          ovf <= 1'b0;
          idx <= IDX_W'(MAG_W-1);
        end
        CMD_MUL_STEP: begin
          // once past the limit the product only grows: hold it
          if (!ovf) begin
            if (pn > (MAG_W+2)'(LIM64)) ovf <= 1'b1;
            else                        p   <= pn;
          end
          idx <= idx - IDX_W'(1);
        end
        CMD_DIV_INIT: begin
          dvd <= a_mag;
          rem <= '0;
          idx <= IDX_W'(MAG_W-1);
        end
        CMD_DIV_STEP: begin
          if (rs >= {1'b0, b_mag}) begin
            rem    <= rs - {1'b0, b_mag};
            q[idx] <= 1'b1;
          end else begin
            rem    <= rs;
            q[idx] <= 1'b0;
          end
          idx <= idx - IDX_W'(1);
        end
        CMD_POW_UPD: begin
          m    <= p[MAG_W-1:0];
          psat <= ovf || (p >= (MAG_W+2)'(LIM64));
          cnt  <= cnt - MAG_W'(1);
        end
        CMD_WRITE: begin
          entry     <= entry_new;
          out_value <= entry_new;
          if (key_f == KEY_CLEAR || key_f == KEY_EQ) begin
            acc <= '0;
            pop <= OP_ADD;
          end else if (is_opkey) begin
            acc <= app_v;
            pop <= op_t'(3'(key_f - KEY_ADD));
          end
        end
        default: ;
      endcase
      // a new word may be written in the cycle the old one is taken
      if (cmd == CMD_WRITE)            out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// File: hdl/calculator_key_engine_core.sv
// ----------------------------------------------------------------------------
// calculator_key_engine_core
// Integer key engine of a pocket calculator, saturating at 13 nines.
// ----------------------------------------------------------------------------
// key_in takes one key word (func, digit); res_out returns one word per key,
// the signed entry value now on the display.
// A key is taken only while the sequencer is idle; the next key is taken
// once the result word has been written to the output register.
// Backspace, and a key that folds a pending div or mod, runs the 44-step
// divider; a pending mul runs the 44-step multiplier; digit, clear, negate
// and unused keys, and a pending add or sub, go straight to write-back.
// A pending pow takes the direct cases straight to write-back, else loops the
// multiplier; the loop stops once the product saturates, at most 43 multiplies.
// The result word becomes valid in the same cycle as the sequencer is idle again.
// The output register holds its word until taken; a result waiting on a
// stalled receiver holds write-back, so a further key waits in the sequencer.
// Reset (synchronous, rst) clears entry and accumulator to zero, sets the
// pending operator to add and empties the output register.
// ----------------------------------------------------------------------------
module calculator_key_engine_core (
  input  logic     clk,
  input  logic     rst,
  ckey_in_if.sink  key_in,
  ckey_out_if.source res_out
);
  import ckey_pkg::*;

  cmd_t  cmd;
  stat_t st;

  ckey_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (key_in.valid),
    .in_ready (key_in.ready),
    .st       (st),
    .cmd      (cmd)
  );

  ckey_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_func   (key_in.func),
    .in_digit  (key_in.digit),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .out_value (res_out.shown_value)
  );

endmodule

// File: hdl/ckey_checker.sv
// ----------------------------------------------------------------------------
// ckey_checker
// Port-level checks on the key engine, bound to the top level.
// ----------------------------------------------------------------------------
module ckey_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [44:0] shown_value
);
  import ckey_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(shown_value))
    else $error("result word changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (shown_value <= LIM) && (shown_value >= -LIM))
    else $error("shown value beyond saturation limit");

  a_one_key: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("key taken while one is in progress");

endmodule

bind calculator_key_engine_core ckey_checker u_ckey_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (key_in.valid),
  .in_ready    (key_in.ready),
  .out_valid   (res_out.valid),
  .out_ready   (res_out.ready),
  .shown_value (res_out.shown_value)
);

// File: dv/calculator_key_engine_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calculator_key_engine_core_tb
// Feeds key words through the key channel and checks every displayed value
// against a saturating calculator predictor, under varying idle and stall patterns.
// ----------------------------------------------------------------------------
module calculator_key_engine_core_tb;
  import ckey_pkg::*;

  typedef struct {
    logic [3:0] func;
    logic [3:0] digit;
  } key_t;

  localparam longint LIMIT = 64'd9999999999999;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ckey_in_if  key_in();
  ckey_out_if res_out();

  calculator_key_engine_core DUT (
    .clk     (clk),
    .rst     (rst),
    .key_in  (key_in.sink),
    .res_out (res_out.source)
  );

  always #5 clk = ~clk;

  key_t   key_q[$];
  longint shown_q[$];
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  bit     hold_req = 0;
  bit     hold_on = 0;
  bit     failed = 0;
  bit     stim_done = 0;

  // predictor state
  longint pr_entry = 0;
  longint pr_acc = 0;
  op_t    pr_op = OP_ADD;

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint sat(longint v);
    if (v < -LIMIT) return -LIMIT;
    if (v > LIMIT) return LIMIT;
    return v;
  endfunction

  function automatic longint calc_power(longint a, longint b);
    longint r;
    bit neg;
    r = a;
    neg = (a < 0) && b[0];
    if (b < 0) return 0;
    if (b == 0) return 1;
    if (a == 0 || a == 1) return a;
    if (a == -1) return b[0] ? -1 : 1;
    for (longint i = b; i > 1; i--) begin
      if (mag(r) > LIMIT / mag(a)) return neg ? -LIMIT : LIMIT;
      r = r * a;
      if (r <= -LIMIT || r >= LIMIT) return neg ? -LIMIT : LIMIT;
    end
    return r;
  endfunction

  function automatic longint fold(longint a, op_t op, longint b);
    longint r;
    case (op)
      OP_SUB: r = a - b;
      OP_MUL: begin
        if (b != 0 && mag(a) > LIMIT / mag(b)) r = ((a < 0) != (b < 0)) ? -LIMIT : LIMIT;
        else r = a * b;
      end
      OP_DIV: r = (b == 0) ? (a < 0 ? -LIMIT : LIMIT) : a / b;
      OP_MOD: r = (b == 0) ? (a < 0 ? -LIMIT : LIMIT) : a % b;
      OP_POW: r = calc_power(a, b);
      default: r = a + b;
    endcase
    return sat(r);
  endfunction

  // advance predictor by one key and return the displayed value
  function automatic longint press_key(key_t k);
    longint d;
    d = (k.digit > 9) ? 9 : k.digit;
    case (k.func)
      KEY_DIGIT: begin
        if (mag(pr_entry) > (LIMIT - d) / 10) pr_entry = pr_entry < 0 ? -LIMIT : LIMIT;
        else pr_entry = pr_entry < 0 ? pr_entry * 10 - d : pr_entry * 10 + d;
      end
      KEY_CLEAR: begin
        pr_entry = 0;
        pr_acc = 0;
        pr_op = OP_ADD;
      end
      KEY_BKSP: pr_entry = pr_entry / 10;
      KEY_NEG:  pr_entry = -pr_entry;
      KEY_EQ: begin
        pr_entry = fold(pr_acc, pr_op, pr_entry);
        pr_acc = 0;
        pr_op = OP_ADD;
      end
      default: begin
        if (k.func >= KEY_ADD && k.func <= KEY_POW) begin
          pr_acc = fold(pr_acc, pr_op, pr_entry);
          pr_entry = 0;
          pr_op = op_t'(3'(k.func - KEY_ADD));
        end
      end
    endcase
    return pr_entry;
  endfunction

  task automatic push_key(input logic [3:0] f, input logic [3:0] d);
    key_t k;
    k.func = f;
    k.digit = d;
    key_q.push_back(k);
  endtask

  task automatic push_number(input int ndig, input bit negative);
    for (int i = 0; i < ndig; i++) push_key(KEY_DIGIT, 4'($urandom_range(9)));
    if (negative) push_key(KEY_NEG, 4'($urandom_range(15)));
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      key_in.valid <= 1'b0;
      key_in.func  <= '0;
      key_in.digit <= '0;
    end else if (!key_in.valid || key_in.ready) begin
      if (key_in.valid) shown_q.push_back(press_key('{key_in.func, key_in.digit}));
      if (key_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        key_t k;
        k = key_q.pop_front();
        key_in.valid <= 1'b1;
        key_in.func  <= k.func;
        key_in.digit <= k.digit;
      end else begin
        key_in.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (600) @(posedge clk);
    hold_on <= 1'b0;
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      res_out.ready <= 1'b0;
    end else begin
      if (res_out.valid && res_out.ready) begin
        if (shown_q.size() == 0) begin
          $error("unexpected word: shown_value %0d", res_out.shown_value);
          failed = 1;
        end else begin
          longint exp_v;
          exp_v = shown_q.pop_front();
          if (res_out.shown_value !== exp_v[44:0]) begin
            $error("shown_value mismatch: expected %0d, actual %0d", exp_v,
                   res_out.shown_value);
            failed = 1;
          end
        end
      end
      if (hold_on) begin
        res_out.ready <= 1'b0;
      end else begin
        res_out.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic wait_drained();
    while (key_q.size() != 0 || key_in.valid || shown_q.size() != 0) @(posedge clk);
  endtask

  task automatic random_keys(input int n);
    for (int i = 0; i < n; i++) begin
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) begin
        // well-formed expression: number, op, number, an optional backspace, equals
        push_number($urandom_range(1, 4), $urandom_range(1));
        push_key(4'(KEY_ADD + $urandom_range(5)), 4'($urandom_range(15)));
        push_number($urandom_range(1, 3), $urandom_range(1));
        if ($urandom_range(3) == 0) push_key(KEY_BKSP, 4'($urandom_range(15)));
        push_key(KEY_EQ, 4'($urandom_range(15)));
      end else if (pick < 70) begin
        push_number($urandom_range(10, 15), $urandom_range(1));
      end else begin
        push_key(4'($urandom_range(15)), 4'($urandom_range(15)));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed part
    push_key(KEY_DIGIT, 4'd15);
    push_key(KEY_DIGIT, 4'd0);
    push_key(KEY_BKSP, 4'd0);
    push_key(KEY_NEG, 4'd0);
    push_key(KEY_POW, 4'd0);
    push_key(KEY_DIGIT, 4'd2);
    push_key(KEY_NEG, 4'd0);
    push_key(KEY_EQ, 4'd0);
    push_key(KEY_DIV, 4'd0);
    push_key(KEY_EQ, 4'd0);
    push_key(KEY_MOD, 4'd0);
    push_key(KEY_EQ, 4'd0);
    // unused key codes
    push_key(4'd11, 4'd5);
    push_key(4'd15, 4'd10);
    push_key(KEY_CLEAR, 4'd0);
    push_number(14, 1);
    push_key(KEY_MUL, 4'd0);
    push_number(3, 0);
    push_key(KEY_SUB, 4'd0);
    push_key(KEY_EQ, 4'd0);
    wait_drained();

    // pressure: long receiver stall while keys keep coming
    hold_req = 1;
    random_keys(10);
    wait_drained();

    recv_stall_pct = 0;  send_idle_pct = 0;  random_keys(70);  wait_drained();
    send_idle_pct = 76;  random_keys(45);  wait_drained();
    send_idle_pct = 0;   recv_stall_pct = 76;  random_keys(45);  wait_drained();
    send_idle_pct = 16;  recv_stall_pct = 16;  random_keys(45);  wait_drained();
    send_idle_pct = 0;   recv_stall_pct = 0;   random_keys(25);  wait_drained();

    repeat (100) @(posedge clk);
    if (!failed)
      $display("calculator_key_engine_core test passed");
    else
      $display("calculator_key_engine_core test failed");
    $finish;
  end

  initial begin
    #200ms;
    $display("calculator_key_engine_core test failed");
    $finish;
  end

endmodule
